[hw/rtl/wildcard_sequence_detector_assert.svh]
// Assertion macros shared by the checker of the wildcard sequence detector.
// Depends on nothing but the simulator's assertion support.
`ifndef WILDCARD_SEQUENCE_DETECTOR_ASSERT_SVH
`define WILDCARD_SEQUENCE_DETECTOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define WSD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define WSD_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[hw/rtl/wsd_pkg.sv]
// Package of the wildcard sequence detector: sizes, codes and cell types.
// Used by every module of the block but the checker; depends on nothing.
`timescale 1ns / 1ps
package wsd_pkg;
  localparam int PatternMax = 16;
  localparam int CntW = $clog2(PatternMax + 1);
  localparam int IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  typedef enum logic [2:0] {
    OP_PUSH_NUM = 3'd0,
    OP_PUSH_NAN = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_EMPTY    = 3'd3,
    OP_APPEND   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_LITERAL  = 2'd0,
    KIND_WILDCARD = 2'd1,
    KIND_NEVER    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_CMP  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // One window entry as it travels down the chain of cells.
  typedef struct packed {
    logic [31:0] value;
    logic        is_int;
    logic        number;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load_pat;
  } cell_ctrl_t;

  function automatic logic bits_finite(input logic [31:0] b);
    return b[30:23] != 8'hFF;
  endfunction
endpackage

[hw/rtl/wsd_i2f.sv]
// Registered int32 to single-precision conversion, round to nearest even.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
module wsd_i2f import wsd_pkg::*; (
  input  logic        clk,
  input  logic [31:0] int_in,
  output logic [31:0] flt_r
);
  logic [31:0] mag;
  logic [4:0]  msb;
  logic [31:0] norm;
  logic [24:0] mant;
  logic        rnd;
  logic [7:0]  expo;
  logic [31:0] flt_nxt;

  always_comb begin
    mag = int_in[31] ? (~int_in + 32'd1) : int_in;
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    norm = mag << (5'd31 - msb);
    rnd = norm[7] & (norm[6] | (|norm[5:0]) | norm[8]);
    mant = {1'b0, norm[31:8]} + {24'd0, rnd};
    expo = 8'd127 + {3'd0, msb} + {7'd0, mant[24]};
    if (mag == 32'd0) begin
      flt_nxt = 32'd0;
    end else begin
      flt_nxt = {int_in[31], expo, mant[24] ? mant[23:1] : mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    flt_r <= flt_nxt;
  end
endmodule

[hw/rtl/wsd_cell.sv]
// One cell of the chain: holds a pattern element and a window entry, shifts
// the entry on to its neighbour and reports whether the two agree.
// Depends on wsd_pkg and wsd_i2f.
`timescale 1ns / 1ps
module wsd_cell import wsd_pkg::*; (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic        pat_sel,
  input  kind_t       pat_kind,
  input  logic [31:0] pat_lit,
  input  slot_t       slot_in,
  output slot_t       slot_r,
  output logic        hit
);
  kind_t       kind_r;
  logic [31:0] lit_r;
  logic [31:0] conv;
  logic [31:0] conv_src;
  logic        num_eq;
  logic [31:0] cmp_val;

  // The conversion register follows the entry, so it is ready with the entry.
  assign conv_src = ctrl.shift ? slot_in.value : slot_r.value;

  wsd_i2f u_i2f (.clk(clk), .int_in(conv_src), .flt_r(conv));

  always_ff @(posedge clk) begin
    if (ctrl.shift) slot_r <= slot_in;
    if (ctrl.load_pat && pat_sel) begin
      kind_r <= pat_kind;
      lit_r  <= pat_lit;
    end
  end

  always_comb begin
    cmp_val = slot_r.is_int ? conv : slot_r.value;
    num_eq = (cmp_val == lit_r) ||
             ((cmp_val[30:0] == 31'd0) && (lit_r[30:0] == 31'd0));
    case (kind_r)
      KIND_WILDCARD: hit = slot_r.number;
      KIND_LITERAL:  hit = slot_r.number && num_eq;
      default:       hit = 1'b0;
    endcase
  end
endmodule

[hw/rtl/wsd_ctrl.sv]
// Sequencer of the detector: pattern length, fill count, compare and emit.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
module wsd_ctrl import wsd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  opcode_t         op,
  input  logic [PatternMax-1:0] hits,
  input  logic            out_fire,
  output cell_ctrl_t      ctrl,
  output logic [CntW-1:0] pat_cnt_r,
  output logic [CntW-1:0] emit_cnt_r,
  output logic            in_ready,
  output logic            emitting
);
  state_t          st_r, st_nxt;
  logic [CntW-1:0] fill_r, fill_nxt, pat_cnt_nxt, emit_cnt_nxt;
  logic            all_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
      fill_r <= '0;
      pat_cnt_r <= '0;
      emit_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      pat_cnt_r <= pat_cnt_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  always_comb begin
    all_hit = 1'b1;
    for (int i = 0; i < PatternMax; i++) begin
      if (CntW'(i) < pat_cnt_r && !hits[i]) all_hit = 1'b0;
    end
    st_nxt = st_r;
    fill_nxt = fill_r;
    pat_cnt_nxt = pat_cnt_r;
    emit_cnt_nxt = emit_cnt_r;
    ctrl = '0;
    in_ready = (st_r == ST_RUN);
    emitting = (st_r == ST_EMIT);
    case (st_r)
      ST_RUN: begin
        if (in_fire) begin
          case (op)
            OP_PUSH_NUM, OP_PUSH_NAN: begin
              if (pat_cnt_r != '0) begin
                ctrl.shift = 1'b1;
                if (fill_r < pat_cnt_r) fill_nxt = fill_r + CntW'(1);
                if (fill_r + CntW'(1) >= pat_cnt_r) st_nxt = ST_CMP;
              end
            end
            OP_CLEAR: fill_nxt = '0;
            OP_EMPTY: begin
              pat_cnt_nxt = '0;
              fill_nxt = '0;
            end
            OP_APPEND: begin
              if (pat_cnt_r < CntW'(PatternMax)) begin
                ctrl.load_pat = 1'b1;
                pat_cnt_nxt = pat_cnt_r + CntW'(1);
                fill_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (all_hit) begin
          st_nxt = ST_EMIT;
          emit_cnt_nxt = '0;
        end else begin
          st_nxt = ST_RUN;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          emit_cnt_nxt = emit_cnt_r + CntW'(1);
          if (emit_cnt_r + CntW'(1) == pat_cnt_r) begin
            st_nxt = ST_RUN;
            fill_nxt = '0;
          end
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end
endmodule

[hw/rtl/wildcard_sequence_detector.sv]
// Wildcard sequence detector: a window of the latest N values is matched
// against an N-element pattern held in a chain of cells.
// Depends on wsd_pkg, wsd_cell and wsd_ctrl.
//
// Usage: commands and values arrive on the in_ stream; matched windows
// leave on the out_ stream, oldest value first, with out_tlast on the
// final value. Cell k holds pattern element k, and the window entry pushed
// most recently sits in the cell of the highest pattern position in use.
// Items are taken while in_tready is high; a push that leaves the window full
// moves to the compare state, in which in_tready is low and no item is taken.
// On a match the N values leave one a cycle while out_tready is high;
// the input is held off until the last value is taken, and a stalled
// receiver simply holds the burst. out_tvalid rises when the state register
// goes on from the compare state to the emit state after the completing push.
// Reset empties the pattern and window at once.
// Each cell converts an integer entry to single precision as it is loaded.
`timescale 1ns / 1ps
module wildcard_sequence_detector import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] opcode, [34:3] value_bits, [36:35] elem_kind, [39:37] zero
  input  logic [39:0] in_tdata,
  input  logic        in_tuser, // [0] is_int
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // [31:0] out_value_bits
  output logic        out_tuser, // [0] out_is_int
  output logic        out_tlast  // last
);
  opcode_t         op;
  logic [31:0]     val;
  logic [1:0]      ek;
  kind_t           kind_in;
  cell_ctrl_t      ctrl;
  logic [CntW-1:0] pat_cnt, emit_cnt;
  logic            in_fire, out_fire, emitting;
  slot_t           new_slot;
  slot_t           slots [PatternMax];
  logic [PatternMax-1:0] hits;
  logic [IdxW-1:0] rd_idx;

  assign op = opcode_t'(in_tdata[2:0]);
  assign val = in_tdata[34:3];
  assign ek = in_tdata[36:35];
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign new_slot = '{value: val, is_int: in_tuser,
    number: (op == OP_PUSH_NUM) && (in_tuser || bits_finite(val))};

  always_comb begin
    if (ek == KIND_WILDCARD) kind_in = KIND_WILDCARD;
    else if (ek == KIND_LITERAL && bits_finite(val)) kind_in = KIND_LITERAL;
    else kind_in = KIND_NEVER;
  end

  wsd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op(op), .hits(hits),
    .out_fire(out_fire), .ctrl(ctrl), .pat_cnt_r(pat_cnt),
    .emit_cnt_r(emit_cnt), .in_ready(in_tready), .emitting(emitting)
  );

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    slot_t nb;
    if (k == PatternMax - 1) begin : g_end
      assign nb = new_slot;
    end else begin : g_mid
      assign nb = (CntW'(k + 1) == pat_cnt) ? new_slot : slots[k + 1];
    end
    wsd_cell u_cell (
      .clk(clk), .ctrl(ctrl), .pat_sel(CntW'(k) == pat_cnt),
      .pat_kind(kind_in), .pat_lit(val), .slot_in(nb),
      .slot_r(slots[k]), .hit(hits[k])
    );
  end

  assign rd_idx = emit_cnt[IdxW-1:0];
  assign out_tvalid = emitting;
  assign out_tdata = slots[rd_idx].value;
  assign out_tuser = slots[rd_idx].is_int;
  assign out_tlast = (emit_cnt + CntW'(1) == pat_cnt);
endmodule

[hw/rtl/wsd_checker.sv]
// Port-level checker of the wildcard sequence detector, bound to the top.
// Depends on wildcard_sequence_detector_assert.svh.
`timescale 1ns / 1ps
`include "wildcard_sequence_detector_assert.svh"
module wsd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic [31:0] out_tdata
);
  `WSD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  `WSD_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))
  `WSD_ASSERT_NXT(a_last_ends, clk, rst_n, out_tvalid && out_tready && out_tlast,
    !out_tvalid)
endmodule

bind wildcard_sequence_detector wsd_checker u_wsd_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tlast(out_tlast), .out_tdata(out_tdata)
);
